@@ rtl/core/pjt_pkg.sv @@
// Shared types, codes and constants for the periodic job timer table.
// No dependencies.
`timescale 1ns / 1ps
package pjt_pkg;
    localparam int SLOTS = 12;
    localparam int SW = $clog2(SLOTS);
    localparam logic [7:0] MIN_INTERVAL_RST = 8'd5;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_TICK = 3'd1, OP_DEL = 3'd2,
        OP_RUN = 3'd3, OP_DONE = 3'd4, OP_QUERY = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        K_ADDED = 4'd0, K_FULL = 4'd1, K_FIRED = 4'd2, K_EXPIRED = 4'd3,
        K_TICK = 4'd4, K_REMOVED = 4'd5, K_RUNST = 4'd6, K_COMPLETED = 4'd7,
        K_INFO = 4'd8, K_EMPTY = 4'd9, K_STALE = 4'd10
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic       latch;      // capture input request
        logic       exec;       // run single-step op
        logic       scan_init;  // start tick scan
        logic       scan_step;  // process slot at scan pointer
        logic       emit_tick;  // push tick done
        logic       out_pop;    // output taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic       out_full;
    } stat_t;
endpackage

@@ rtl/core/pjt_datapath.sv @@
// Datapath: slot table, time and id counters, result register.
// Depends on pjt_pkg.
`timescale 1ns / 1ps
module pjt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pjt_pkg::cmd_t        cmd,
    output pjt_pkg::stat_t       stat,
    input  logic [7:0]           min_interval,
    input  logic [2:0]           opcode,
    input  logic [23:0]          interval_s,
    input  logic [23:0]          ttl_s,
    input  logic                 is_global,
    input  logic [15:0]          command_tag,
    input  logic [23:0]          target_id,
    input  logic                 delete_all,
    input  logic                 run_enable,
    input  logic [3:0]           slot_index,
    input  logic signed [31:0]   return_code,
    output logic [3:0]           kind,
    output logic [3:0]           slot,
    output logic [23:0]          job_id,
    output logic [15:0]          command_out,
    output logic                 global_flag,
    output logic [31:0]          count,
    output logic [23:0]          interval_out,
    output logic [31:0]          remaining_s,
    output logic signed [31:0]   last_code,
    output logic                 running,
    output logic                 persist_changed,
    output logic                 last
);
    localparam int SL = pjt_pkg::SLOTS;
    localparam int SW = pjt_pkg::SW;

    // latched request
    logic [2:0]  op_reg;
    logic [23:0] intv_reg, ttl_reg, tgt_reg;
    logic        glob_reg, all_reg, ren_reg;
    logic [15:0] cmdtag_reg;
    logic [3:0]  idx_reg;
    logic [31:0] code_reg;

    logic [31:0] now_reg;
    logic [23:0] nid_reg;
    logic        run_reg;
    logic [SL-1:0] used_reg;
    logic [23:0] s_id  [SL];
    logic [23:0] s_iv  [SL];
    logic [31:0] s_due [SL];
    logic [31:0] s_exp [SL];
    logic        s_gl  [SL];
    logic [31:0] s_runs[SL];
    logic [31:0] s_code[SL];
    logic [15:0] s_cmd [SL];

    logic [SW-1:0] ptr_reg;
    logic          scan_reg;

    // output register occupancy
    logic        full_reg;

    // first free slot
    logic          free_found;
    logic [SW-1:0] free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SL - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    logic idx_ok;
    logic [SW-1:0] idx;
    assign idx_ok = ({28'd0, idx_reg} < SL) && used_reg[idx_reg[SW-1:0]];
    assign idx    = idx_reg[SW-1:0];

    logic [23:0] every;
    always_comb
    begin
        every = intv_reg;
        if (intv_reg != 24'd0 && intv_reg < {16'd0, min_interval})
            every = {16'd0, min_interval};
    end

    // delete match vector and count
    logic [SL-1:0] del_hit;
    logic [5:0]    del_n;
    logic          del_touch;
    always_comb
    begin
        del_n = '0;
        del_touch = 1'b0;
        for (int i = 0; i < SL; i++)
        begin
            del_hit[i] = used_reg[i] && (all_reg || s_id[i] == tgt_reg);
            del_n = del_n + 6'(del_hit[i]);
            del_touch = del_touch | (del_hit[i] & s_gl[i]);
        end
    end

    logic [23:0] nid_inc;
    assign nid_inc = nid_reg + 24'd1;

    logic [31:0] p_exp, p_due;
    logic [23:0] p_iv;
    logic p_used, p_expired, p_fire;
    assign p_used    = used_reg[ptr_reg];
    assign p_exp     = s_exp[ptr_reg];
    assign p_due     = s_due[ptr_reg];
    assign p_iv      = s_iv[ptr_reg];
    assign p_expired = (p_exp != 32'd0) && (now_reg > p_exp);
    assign p_fire    = now_reg >= p_due;

    assign stat.scan_done   = !scan_reg;
    assign stat.out_full    = full_reg;
    assign running          = run_reg;

    // one result goes to the output register; helper to fill from a slot
    logic          push;
    logic [3:0]    pk;
    logic [3:0]    ps;
    logic          pslot;
    logic [SW-1:0] psi;
    logic [31:0]   pcount, prem;
    logic          ppers, plast;
    always_comb
    begin
        push = 1'b0; pk = pjt_pkg::K_TICK; ps = '0; pslot = 1'b0; psi = '0;
        pcount = '0; prem = '0; ppers = 1'b0; plast = 1'b1;
        if (cmd.exec)
        begin
            push = 1'b1;
            case (op_reg)
                pjt_pkg::OP_ADD:
                begin
                    if (free_found)
                    begin
                        pk = pjt_pkg::K_ADDED; pslot = 1'b1; psi = free_idx;
                        ps = 4'(free_idx); ppers = glob_reg;
                    end
                    else
                        pk = pjt_pkg::K_FULL;
                end
                pjt_pkg::OP_DEL:
                begin
                    pk = pjt_pkg::K_REMOVED; pcount = 32'(del_n); ppers = del_touch;
                end
                pjt_pkg::OP_RUN: pk = pjt_pkg::K_RUNST;
                pjt_pkg::OP_DONE:
                begin
                    ps = idx_reg;
                    if (idx_ok)
                    begin
                        pk = pjt_pkg::K_COMPLETED; pslot = 1'b1; psi = idx;
                        ppers = (s_iv[idx] == 24'd0) & s_gl[idx];
                    end
                    else
                        pk = pjt_pkg::K_STALE;
                end
                pjt_pkg::OP_QUERY:
                begin
                    ps = idx_reg;
                    if (idx_ok)
                    begin
                        pk = pjt_pkg::K_INFO; pslot = 1'b1; psi = idx;
                        if (s_exp[idx] != 32'd0 && s_exp[idx] > now_reg)
                            prem = s_exp[idx] - now_reg;
                    end
                    else
                        pk = pjt_pkg::K_EMPTY;
                end
                default: push = 1'b0;
            endcase
        end
        else if (cmd.scan_step && p_used && (p_expired || p_fire))
        begin
            push = 1'b1; pslot = 1'b1; psi = ptr_reg; ps = 4'(ptr_reg); plast = 1'b0;
            if (p_expired)
            begin
                pk = pjt_pkg::K_EXPIRED; ppers = s_gl[ptr_reg];
            end
            else
                pk = pjt_pkg::K_FIRED;
        end
        else if (cmd.emit_tick)
            push = 1'b1;
    end

    // values shown reflect the table after the op (completion increments)
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind <= pk; slot <= ps; remaining_s <= prem; last <= plast;
            persist_changed <= ppers;
            count <= pcount;
            job_id <= '0; command_out <= '0; global_flag <= 1'b0;
            interval_out <= '0; last_code <= '0;
            if (pslot)
            begin
                if (cmd.exec && op_reg == pjt_pkg::OP_ADD)
                begin
                    job_id <= nid_reg; command_out <= cmdtag_reg;
                    global_flag <= glob_reg; interval_out <= every;
                end
                else
                begin
                    job_id <= s_id[psi]; command_out <= s_cmd[psi];
                    global_flag <= s_gl[psi]; interval_out <= s_iv[psi];
                    count <= s_runs[psi] + 32'(cmd.exec);
                    last_code <= cmd.exec ? code_reg : s_code[psi];
                    if (cmd.exec && op_reg == pjt_pkg::OP_QUERY)
                    begin
                        count <= s_runs[psi];
                        last_code <= s_code[psi];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            if (push)
                full_reg <= 1'b1;
            else if (cmd.out_pop)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= opcode; intv_reg <= interval_s; ttl_reg <= ttl_s;
            glob_reg <= is_global; cmdtag_reg <= command_tag; tgt_reg <= target_id;
            all_reg <= delete_all; ren_reg <= run_enable; idx_reg <= slot_index;
            code_reg <= return_code;
        end
        if (cmd.exec && op_reg == pjt_pkg::OP_ADD && free_found)
        begin
            s_id[free_idx]  <= nid_reg;
            s_iv[free_idx]  <= every;
            s_due[free_idx] <= now_reg + ((every != 24'd0) ? {8'd0, every} : 32'd1);
            s_exp[free_idx] <= (ttl_reg != 24'd0) ? now_reg + {8'd0, ttl_reg} : 32'd0;
            s_gl[free_idx]  <= glob_reg;
            s_runs[free_idx] <= '0;
            s_code[free_idx] <= '0;
            s_cmd[free_idx] <= cmdtag_reg;
        end
        if (cmd.exec && op_reg == pjt_pkg::OP_DONE && idx_ok)
        begin
            s_runs[idx] <= s_runs[idx] + 32'd1;
            s_code[idx] <= code_reg;
        end
        if (cmd.scan_step && p_used && !p_expired && p_fire)
            s_due[ptr_reg] <= now_reg + ((p_iv != 24'd0) ? {8'd0, p_iv} : 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0; nid_reg <= 24'd1; run_reg <= 1'b1; used_reg <= '0;
            ptr_reg <= '0; scan_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (op_reg)
                    pjt_pkg::OP_ADD:
                        if (free_found)
                        begin
                            used_reg[free_idx] <= 1'b1;
                            nid_reg <= (nid_inc == 24'd0) ? 24'd1 : nid_inc;
                        end
                    pjt_pkg::OP_DEL: used_reg <= used_reg & ~del_hit;
                    pjt_pkg::OP_RUN: run_reg <= ren_reg;
                    pjt_pkg::OP_DONE:
                        if (idx_ok && s_iv[idx] == 24'd0)
                            used_reg[idx] <= 1'b0;
                    default: ;
                endcase
            end
            if (cmd.scan_init)
            begin
                now_reg <= now_reg + 32'd1;
                ptr_reg <= '0;
                scan_reg <= run_reg;
            end
            else if (cmd.scan_step)
            begin
                if (p_used && p_expired)
                    used_reg[ptr_reg] <= 1'b0;
                if (ptr_reg == SW'(SL - 1))
                    scan_reg <= 1'b0;
                else
                    ptr_reg <= ptr_reg + SW'(1);
            end
        end
    end
endmodule

@@ rtl/core/pjt_ctrl.sv @@
// Controller state machine: request intake, tick scan sequencing, output.
// Depends on pjt_pkg.
`timescale 1ns / 1ps
module pjt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     opcode,
    output logic           out_valid,
    input  logic           out_ready,
    output pjt_pkg::cmd_t  cmd,
    input  pjt_pkg::stat_t stat
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_INIT = 5'b00100,
        S_SCAN = 5'b01000, S_TICK = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   pop;

    assign out_valid = stat.out_full;
    assign pop       = out_valid && out_ready;
    // a new result may be written when register is empty or being drained
    logic room;
    assign room = !stat.out_full || out_ready;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.out_pop = pop;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (opcode == pjt_pkg::OP_TICK)
                        state_next = S_INIT;
                    else if (opcode inside {[pjt_pkg::OP_ADD:pjt_pkg::OP_QUERY]})
                        state_next = S_EXEC;
                end
            S_EXEC:
                if (room)
                begin
                    cmd.exec = 1'b1;
                    state_next = S_IDLE;
                end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
                if (stat.scan_done)
                    state_next = S_TICK;
                else if (room)
                    cmd.scan_step = 1'b1;
            S_TICK:
                if (room)
                begin
                    cmd.emit_tick = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

@@ rtl/core/periodic_job_timer_table_core.sv @@
// Top level of the periodic job timer table: config register, controller, datapath.
// Depends on pjt_pkg, pjt_ctrl, pjt_datapath.
`timescale 1ns / 1ps
// A table of 12 job timers at one-second resolution. Each request on the input
// channel other than opcodes 6 and 7 produces one or more results on the output
// channel; the final one has last set. Add, delete, run state, completion and
// query load their one result into the output register from the execute state
// (S_EXEC) once the output register has room, and the next request can then be
// accepted. Opcodes 6 and 7 give no result. A tick advances time in the init
// state (S_INIT), then the controller walks the slots one per cycle while the
// output register has room, sees the end of the walk and loads tick done from
// the tick state (S_TICK). A paused tick skips the walk. Every cycle in which
// the output register holds a result that is not taken holds the walk or the
// result load for that cycle.
// A new request is taken only after the previous one has loaded all results.
// min_interval is to be written through the cfg channel only while the block
// is idle; the block itself does not enforce this.
module periodic_job_timer_table_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic [23:0]          interval_s,
    input  logic [23:0]          ttl_s,
    input  logic                 is_global,
    input  logic [15:0]          command_tag,
    input  logic [23:0]          target_id,
    input  logic                 delete_all,
    input  logic                 run_enable,
    input  logic [3:0]           slot_index,
    input  logic signed [31:0]   return_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           kind,
    output logic [3:0]           slot,
    output logic [23:0]          job_id,
    output logic [15:0]          command_out,
    output logic                 global_flag,
    output logic [31:0]          count,
    output logic [23:0]          interval_out,
    output logic [31:0]          remaining_s,
    output logic signed [31:0]   last_code,
    output logic                 running,
    output logic                 persist_changed,
    output logic                 last
);
    logic [7:0] min_interval_reg;
    pjt_pkg::cmd_t  cmd;
    pjt_pkg::stat_t stat;

    // config register always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_interval_reg <= pjt_pkg::MIN_INTERVAL_RST;
        else if (cfg_valid)
            min_interval_reg <= cfg_data;
    end

    pjt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat)
    );

    pjt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .min_interval(min_interval_reg),
        .opcode(opcode), .interval_s(interval_s), .ttl_s(ttl_s),
        .is_global(is_global), .command_tag(command_tag), .target_id(target_id),
        .delete_all(delete_all), .run_enable(run_enable), .slot_index(slot_index),
        .return_code(return_code),
        .kind(kind), .slot(slot), .job_id(job_id), .command_out(command_out),
        .global_flag(global_flag), .count(count), .interval_out(interval_out),
        .remaining_s(remaining_s), .last_code(last_code), .running(running),
        .persist_changed(persist_changed), .last(last)
    );
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for periodic_job_timer_table_core.
// Directed table, a settings sweep, then random requests, checked against an in-bench job table predictor.
// Depends on pjt_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM = 175;
    localparam int SLOTS = pjt_pkg::SLOTS;

    // one expected result
    typedef struct {
        pjt_pkg::kind_t knd;
        logic [3:0]  slt;
        logic [23:0] jid;
        logic [15:0] cmd;
        logic        glb;
        logic [31:0] cnt;
        logic [23:0] ivl;
        logic [31:0] rem;
        logic [31:0] code;
        logic        run;
        logic        pch;
        logic        lst;
    } job_result_t;

    // one request
    typedef struct {
        pjt_pkg::op_t op;
        logic [23:0] ivl;
        logic [23:0] ttl;
        logic        glb;
        logic [15:0] tag;
        logic [23:0] tid;
        logic        all;
        logic        ren;
        logic [3:0]  idx;
        logic [31:0] rc;
        logic        fixed;      // expected first result typed in below
        pjt_pkg::kind_t fx_kind;
        logic [23:0] fx_id;
        logic [31:0] fx_cnt;
    } job_req_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [7:0] cfg_data;
    logic in_valid, in_ready;
    logic [2:0] opcode;
    logic [23:0] interval_s, ttl_s, target_id;
    logic is_global, delete_all, run_enable;
    logic [15:0] command_tag;
    logic [3:0] slot_index;
    logic signed [31:0] return_code;
    logic out_valid, out_ready;
    logic [3:0] kind, slot;
    logic [23:0] job_id, interval_out;
    logic [15:0] command_out;
    logic global_flag, running, persist_changed, last;
    logic [31:0] count, remaining_s;
    logic signed [31:0] last_code;

    periodic_job_timer_table_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .interval_s(interval_s), .ttl_s(ttl_s), .is_global(is_global),
        .command_tag(command_tag), .target_id(target_id), .delete_all(delete_all),
        .run_enable(run_enable), .slot_index(slot_index), .return_code(return_code),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .slot(slot),
        .job_id(job_id), .command_out(command_out), .global_flag(global_flag),
        .count(count), .interval_out(interval_out), .remaining_s(remaining_s),
        .last_code(last_code), .running(running), .persist_changed(persist_changed),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor state: a shadow copy of the job table
    // ---------------------------------------------------------------
    logic [7:0]  p_min_ivl;
    logic [31:0] p_now;
    logic [23:0] p_next_id;
    logic        p_run;
    logic        p_used  [SLOTS];
    logic [23:0] p_id    [SLOTS];
    logic [23:0] p_ivl   [SLOTS];
    logic [31:0] p_due   [SLOTS];
    logic [31:0] p_exp   [SLOTS];
    logic        p_glb   [SLOTS];
    logic [31:0] p_runs  [SLOTS];
    logic [31:0] p_code  [SLOTS];
    logic [15:0] p_cmd   [SLOTS];

    job_result_t pending_results[$];
    job_result_t step_buf[$];
    int errors = 0;

    function automatic job_result_t blank_result(pjt_pkg::kind_t k, logic [3:0] s);
        job_result_t r;
        r = '{knd: k, slt: s, default: '0};
        return r;
    endfunction

    function automatic job_result_t slot_result(pjt_pkg::kind_t k, int s);
        job_result_t r;
        r = blank_result(k, 4'(s));
        r.jid = p_id[s];
        r.cmd = p_cmd[s];
        r.glb = p_glb[s];
        r.cnt = p_runs[s];
        r.ivl = p_ivl[s];
        r.code = p_code[s];
        return r;
    endfunction

    // Apply one request to the shadow table and queue what it should produce.
    function automatic void predict_job_results(job_req_t q);
        job_result_t r;
        logic [23:0] every;
        logic [31:0] n;
        logic touched;
        int found;
        step_buf.delete();
        case (q.op)
            pjt_pkg::OP_ADD:
            begin
                found = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (found < 0 && !p_used[s]) found = s;
                if (found < 0) step_buf.push_back(blank_result(pjt_pkg::K_FULL, 4'd0));
                else
                begin
                    every = q.ivl;
                    // zero min_interval means no raise, falls out naturally
                    if (every != 0 && every < {16'd0, p_min_ivl}) every = {16'd0, p_min_ivl};
                    p_used[found] = 1'b1;
                    p_id[found] = p_next_id;
                    p_next_id = p_next_id + 24'd1;
                    if (p_next_id == 0) p_next_id = 24'd1;   // id 0 is never handed out
                    p_ivl[found] = every;
                    p_due[found] = p_now + ((every != 0) ? {8'd0, every} : 32'd1);
                    p_exp[found] = (q.ttl != 0) ? p_now + {8'd0, q.ttl} : 32'd0;
                    p_glb[found] = q.glb;
                    p_runs[found] = '0;
                    p_code[found] = '0;
                    p_cmd[found] = q.tag;
                    r = slot_result(pjt_pkg::K_ADDED, found);
                    r.pch = q.glb;
                    step_buf.push_back(r);
                end
            end
            pjt_pkg::OP_TICK:
            begin
                p_now = p_now + 32'd1;
                if (p_run)
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!p_used[s]) continue;
                        if (p_exp[s] != 0 && p_now > p_exp[s])
                        begin
                            p_used[s] = 1'b0;
                            r = slot_result(pjt_pkg::K_EXPIRED, s);
                            r.pch = p_glb[s];
                            step_buf.push_back(r);
                        end
                        else if (p_now >= p_due[s])
                        begin
                            p_due[s] = p_now + ((p_ivl[s] != 0) ? {8'd0, p_ivl[s]} : 32'd1);
                            step_buf.push_back(slot_result(pjt_pkg::K_FIRED, s));
                        end
                    end
                step_buf.push_back(blank_result(pjt_pkg::K_TICK, 4'd0));
            end
            pjt_pkg::OP_DEL:
            begin
                n = '0;
                touched = 1'b0;
                for (int s = 0; s < SLOTS; s++)
                    if (p_used[s] && (q.all || p_id[s] == q.tid))
                    begin
                        touched |= p_glb[s];
                        p_used[s] = 1'b0;
                        n++;
                    end
                r = blank_result(pjt_pkg::K_REMOVED, 4'd0);
                r.cnt = n;
                r.pch = touched;
                step_buf.push_back(r);
            end
            pjt_pkg::OP_RUN:
            begin
                p_run = q.ren;
                step_buf.push_back(blank_result(pjt_pkg::K_RUNST, 4'd0));
            end
            pjt_pkg::OP_DONE:
            begin
                if (q.idx >= SLOTS || !p_used[q.idx])
                    step_buf.push_back(blank_result(pjt_pkg::K_STALE, q.idx));
                else
                begin
                    p_runs[q.idx] = p_runs[q.idx] + 32'd1;
                    p_code[q.idx] = q.rc;
                    r = slot_result(pjt_pkg::K_COMPLETED, q.idx);
                    if (p_ivl[q.idx] == 0)
                    begin
                        p_used[q.idx] = 1'b0;
                        r.pch = p_glb[q.idx];
                    end
                    step_buf.push_back(r);
                end
            end
            pjt_pkg::OP_QUERY:
            begin
                if (q.idx >= SLOTS || !p_used[q.idx])
                    step_buf.push_back(blank_result(pjt_pkg::K_EMPTY, q.idx));
                else
                begin
                    r = slot_result(pjt_pkg::K_INFO, q.idx);
                    if (p_exp[q.idx] != 0 && p_exp[q.idx] > p_now)
                        r.rem = p_exp[q.idx] - p_now;
                    step_buf.push_back(r);
                end
            end
            default: ;   // opcodes 6 and 7: no effect, no result
        endcase
        // running reflects the state after the request, on every result
        foreach (step_buf[i])
        begin
            step_buf[i].run = p_run;
            step_buf[i].lst = (i == step_buf.size() - 1);
            pending_results.push_back(step_buf[i]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall, compare against oldest expectation
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        job_result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: kind=%0d", kind);
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (kind !== e.knd)
                    begin
                        $error("kind exp %0d got %0d", e.knd, kind); errors++; end
                    if (slot !== e.slt)
                    begin
                        $error("slot exp %0d got %0d", e.slt, slot); errors++; end
                    if (job_id !== e.jid)
                    begin
                        $error("job_id exp %0h got %0h", e.jid, job_id); errors++; end
                    if (command_out !== e.cmd)
                    begin
                        $error("command_out exp %0h got %0h", e.cmd, command_out); errors++; end
                    if (global_flag !== e.glb)
                    begin
                        $error("global_flag exp %0b got %0b", e.glb, global_flag); errors++; end
                    if (count !== e.cnt)
                    begin
                        $error("count exp %0d got %0d", e.cnt, count); errors++; end
                    if (interval_out !== e.ivl)
                    begin
                        $error("interval_out exp %0d got %0d", e.ivl, interval_out); errors++; end
                    if (remaining_s !== e.rem)
                    begin
                        $error("remaining_s exp %0d got %0d", e.rem, remaining_s); errors++; end
                    if (last_code !== e.code)
                    begin
                        $error("last_code exp %0h got %0h", e.code, last_code); errors++; end
                    if (running !== e.run)
                    begin
                        $error("running exp %0b got %0b", e.run, running); errors++; end
                    if (persist_changed !== e.pch)
                    begin
                        $error("persist_changed exp %0b got %0b", e.pch, persist_changed);
                        errors++;
                    end
                    if (last !== e.lst)
                    begin
                        $error("last exp %0b got %0b", e.lst, last); errors++; end
                end
                // fresh stall for the next result; at least one in four has none at all
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles without any handshake
    // ---------------------------------------------------------------
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // drops the input request, then waits until every expected result is in
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_min_interval(logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        p_min_ivl = v;
    endtask

    // valid stays high across back-to-back requests; it drops only for a gap
    task automatic send_request(job_req_t q);
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= 3'(q.op);
        interval_s <= q.ivl; ttl_s <= q.ttl; is_global <= q.glb;
        command_tag <= q.tag; target_id <= q.tid; delete_all <= q.all;
        run_enable <= q.ren; slot_index <= q.idx; return_code <= q.rc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_job_results(q);
    endtask

    function automatic job_req_t mk(pjt_pkg::op_t op, logic [23:0] ivl = '0,
                                    logic [23:0] ttl = '0, logic glb = 1'b0,
                                    logic [15:0] tag = '0, logic [23:0] tid = '0,
                                    logic all = 1'b0, logic ren = 1'b0,
                                    logic [3:0] idx = '0, logic [31:0] rc = '0);
        job_req_t q;
        q = '{op: op, ivl: ivl, ttl: ttl, glb: glb, tag: tag, tid: tid, all: all,
              ren: ren, idx: idx, rc: rc, fixed: 1'b0,
              fx_kind: pjt_pkg::K_ADDED, fx_id: '0, fx_cnt: '0};
        return q;
    endfunction

    function automatic job_req_t with_fixed(job_req_t q, pjt_pkg::kind_t k,
                                            logic [23:0] id, logic [31:0] c);
        q.fixed = 1'b1; q.fx_kind = k; q.fx_id = id; q.fx_cnt = c;
        return q;
    endfunction

    // random request: mostly adds, ticks and completions
    function automatic job_req_t random_request();
        job_req_t q;
        int sel;
        pjt_pkg::op_t op;
        sel = $urandom_range(0, 99);
        if (sel < 25) op = pjt_pkg::OP_ADD;
        else if (sel < 60) op = pjt_pkg::OP_TICK;
        else if (sel < 67) op = pjt_pkg::OP_DEL;
        else if (sel < 72) op = pjt_pkg::OP_RUN;
        else if (sel < 87) op = pjt_pkg::OP_DONE;
        else op = pjt_pkg::OP_QUERY;
        q = mk(op);
        q.ivl = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12));
        q.ttl = ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                ($urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(1, 30)));
        q.glb = 1'($urandom_range(0, 1));
        q.tag = 16'($urandom);
        q.tid = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
        q.all = ($urandom_range(0, 5) == 0);
        q.ren = ($urandom_range(0, 3) != 0);
        q.idx = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, SLOTS - 1));
        q.rc = $urandom;
        if ($urandom_range(0, 49) == 0) q.op = pjt_pkg::op_t'(3'($urandom_range(6, 7)));
        return q;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    job_req_t plan[$];
    job_req_t q;

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        in_valid = 1'b0; opcode = '0; interval_s = '0; ttl_s = '0; is_global = 1'b0;
        command_tag = '0; target_id = '0; delete_all = 1'b0; run_enable = 1'b0;
        slot_index = '0; return_code = '0;
        p_min_ivl = pjt_pkg::MIN_INTERVAL_RST;
        p_now = '0; p_next_id = 24'd1; p_run = 1'b1;
        for (int s = 0; s < SLOTS; s++)
        begin
            p_used[s] = 0; p_id[s] = 0; p_ivl[s] = 0; p_due[s] = 0; p_exp[s] = 0;
            p_glb[s] = 0; p_runs[s] = 0; p_code[s] = 0; p_cmd[s] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. First rows after reset have results readable by eye.
        plan.push_back(with_fixed(mk(pjt_pkg::OP_QUERY, .idx(4'd0)),
                                  pjt_pkg::K_EMPTY, 24'd0, 32'd0));
        plan.push_back(with_fixed(mk(pjt_pkg::OP_QUERY, .idx(4'd15)),
                                  pjt_pkg::K_EMPTY, 24'd0, 32'd0));
        plan.push_back(with_fixed(mk(pjt_pkg::OP_DONE, .idx(4'd12), .rc(32'h8000_0000)),
                                  pjt_pkg::K_STALE, 24'd0, 32'd0));
        plan.push_back(with_fixed(mk(pjt_pkg::OP_ADD, .ivl(24'd1), .tag(16'hFFFF),
                                     .glb(1'b1)),
                                  pjt_pkg::K_ADDED, 24'd1, 32'd0));   // raised to 5
        plan.push_back(with_fixed(mk(pjt_pkg::OP_ADD, .ttl(24'd2)),
                                  pjt_pkg::K_ADDED, 24'd2, 32'd0));   // run once
        plan.push_back(mk(pjt_pkg::OP_ADD, .ivl(24'hFFFFFF), .ttl(24'hFFFFFF)));
        plan.push_back(mk(pjt_pkg::OP_TICK));
        plan.push_back(mk(pjt_pkg::OP_TICK));
        plan.push_back(mk(pjt_pkg::OP_TICK));          // run-once job expires
        plan.push_back(mk(pjt_pkg::OP_DONE, .idx(4'd0), .rc(32'h7FFF_FFFF)));
        plan.push_back(mk(pjt_pkg::OP_QUERY, .idx(4'd2)));
        plan.push_back(mk(pjt_pkg::OP_RUN, .ren(1'b0)));
        plan.push_back(mk(pjt_pkg::OP_TICK));          // paused: only tick done
        plan.push_back(mk(pjt_pkg::OP_RUN, .ren(1'b1)));
        plan.push_back(with_fixed(mk(pjt_pkg::OP_DEL, .tid(24'hABCDEF)),
                                  pjt_pkg::K_REMOVED, 24'd0, 32'd0));
        plan.push_back(mk(pjt_pkg::OP_DEL, .tid(24'd1)));
        for (int i = 0; i < 13; i++)
            plan.push_back(mk(pjt_pkg::OP_ADD, .ivl(24'd3), .glb(i[0])));
        plan[$] = with_fixed(plan[$], pjt_pkg::K_FULL, 24'd0, 32'd0);  // table full
        plan.push_back(mk(pjt_pkg::op_t'(3'd6)));
        plan.push_back(mk(pjt_pkg::op_t'(3'd7)));
        plan.push_back(mk(pjt_pkg::OP_TICK));
        plan.push_back(mk(pjt_pkg::OP_DEL, .all(1'b1)));

        foreach (plan[i])
        begin
            q = plan[i];
            send_request(q);
            if (q.fixed)
            begin
                if (step_buf.size() == 0 || step_buf[0].knd != q.fx_kind
                    || step_buf[0].jid != q.fx_id || step_buf[0].cnt != q.fx_cnt)
                begin
                    $error("directed row %0d: kind exp %0d got %0d", i, q.fx_kind,
                           step_buf[0].knd);
                    errors++;
                end
            end
        end

        // settings sweep: extremes and a zero (no raise) setting
        write_min_interval(8'd255);
        send_request(mk(pjt_pkg::OP_ADD, .ivl(24'd7)));
        write_min_interval(8'd0);
        send_request(mk(pjt_pkg::OP_ADD, .ivl(24'd1)));
        write_min_interval(8'd1);

        // random part, with a min_interval write and a mid-run pause until everything has drained
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2) write_min_interval(8'($urandom_range(1, 255)));
            if (i == N_RANDOM / 3) wait_drained();
            send_request(random_request());
        end

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
